@@ rtl/sha512_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-512 package
// Shared types, round constants and round functions of the block hash engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

	localparam int WordW = 64;
	localparam int Rounds = 80;
	localparam int FifoDepth = 4;

	typedef logic [WordW-1:0] word_t;

	// One classified message word handed from the front to the compression core.
	typedef struct packed {
		word_t word;
		logic  first;     // reload the initial hash value before this word
		logic  blk_end;   // sixteenth word of its block
		logic  emit;      // block closes the message: send the digest
	} entry_t;

	localparam word_t ROUND_K [Rounds] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	localparam word_t START_H [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	function automatic word_t rotr(input word_t v, input int n);
		return (v >> n) | (v << (WordW - n));
	endfunction

	function automatic word_t sig_lo(input word_t v);
		return rotr(v, 1) ^ rotr(v, 8) ^ (v >> 7);
	endfunction

	function automatic word_t sig_hi(input word_t v);
		return rotr(v, 19) ^ rotr(v, 61) ^ (v >> 6);
	endfunction

	function automatic word_t sum_a(input word_t v);
		return rotr(v, 28) ^ rotr(v, 34) ^ rotr(v, 39);
	endfunction

	function automatic word_t sum_e(input word_t v);
		return rotr(v, 14) ^ rotr(v, 18) ^ rotr(v, 41);
	endfunction

endpackage

@@ rtl/sha512_fifo.sv @@
// ----------------------------------------------------------------------------
// SHA-512 word queue
// Four-entry queue of classified words between the front and the core.
// ----------------------------------------------------------------------------
module sha512_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sha512_pkg::entry_t  push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output sha512_pkg::entry_t  pop_data
);
	import sha512_pkg::*;

	localparam int PtrW = $clog2(FifoDepth);

	entry_t            mem_q [FifoDepth];
	logic [PtrW-1:0]   wr_q, rd_q;
	logic [PtrW:0]     cnt_q;

	assign full      = (cnt_q == (PtrW+1)'(FifoDepth));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && not_empty) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push && !full) - (PtrW+1)'(pop && not_empty);
		end
	end

endmodule

@@ rtl/sha512_front.sv @@
// ----------------------------------------------------------------------------
// SHA-512 front end
// Accepts message words, tracks block position and marks block and message ends.
// ----------------------------------------------------------------------------
module sha512_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha512_pkg::word_t   in_word,
	input  logic                in_first,
	input  logic                in_last,
	output logic                push,
	output sha512_pkg::entry_t  push_data,
	input  logic                q_full
);
	import sha512_pkg::*;

	logic [3:0] count_q;
	logic       ends_q;
	logic [3:0] idx;
	logic       ends;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// A start marker drops any partly gathered block.
	assign idx  = in_first ? 4'd0 : count_q;
	assign ends = (in_first ? 1'b0 : ends_q) | in_last;

	always_comb begin
		push_data.word    = in_word;
		push_data.first   = in_first;
		push_data.blk_end = (idx == 4'd15);
		push_data.emit    = (idx == 4'd15) && ends;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ends_q  <= 1'b0;
		end else if (push) begin
			count_q <= idx + 4'd1;
			ends_q  <= (idx == 4'd15) ? 1'b0 : ends;
		end
	end

endmodule

@@ rtl/sha512_core.sv @@
// ----------------------------------------------------------------------------
// SHA-512 compression core
// Loads a block, runs 80 rounds one per cycle, adds into the state, emits digest after a final block.
// ----------------------------------------------------------------------------
module sha512_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  sha512_pkg::entry_t  q_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output sha512_pkg::word_t   out_word,
	output logic [2:0]          out_index,
	output logic                out_last
);
	import sha512_pkg::*;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [6:0] rnd_q;
	logic       emit_q;
	logic [2:0] ecnt_q;
	word_t      w_q [16];
	word_t      h_q [8];
	word_t      v_q [8];
	word_t      w_new, t1, t2;
	logic       load_out;

	assign pop = (state_q == ST_LOAD) && q_valid;

	always_comb begin
		w_new = sig_hi(w_q[14]) + w_q[9] + sig_lo(w_q[1]) + w_q[0];
		t1 = v_q[7] + sum_e(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[rnd_q] + w_q[0];
		t2 = sum_a(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign load_out = (state_q == ST_EMIT) && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		if (pop || state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= pop ? q_data.word : w_new;
		end
		if (pop && q_data.blk_end) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == ST_ROUND) begin
			for (int i = 1; i < 8; i++) begin
				if (i != 4) v_q[i] <= v_q[i-1];
			end
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end
		if (load_out) begin
			out_word  <= h_q[ecnt_q];
			out_index <= ecnt_q;
			out_last  <= (ecnt_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			rnd_q     <= '0;
			emit_q    <= 1'b0;
			ecnt_q    <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= START_H[i];
		end else begin
			if (load_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (q_data.first) begin
							for (int i = 0; i < 8; i++) h_q[i] <= START_H[i];
						end
						if (q_data.blk_end) begin
							emit_q  <= q_data.emit;
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					if (rnd_q == 7'(Rounds - 1)) begin
						rnd_q   <= '0;
						state_q <= ST_ADD;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					ecnt_q  <= '0;
					state_q <= emit_q ? ST_EMIT : ST_LOAD;
				end
				ST_EMIT: begin
					if (load_out) begin
						ecnt_q <= ecnt_q + 3'd1;
						if (ecnt_q == 3'd7) state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> rnd_q < 7'(Rounds)) else $error("round count out of range");
	a_pop_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_LOAD) else $error("queue read outside load");
	a_add_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |=> state_q != ST_ADD) else $error("state add repeated");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_last == (out_index == 3'd7)) else $error("last marker mismatch");

endmodule

@@ rtl/sha512_block_hash.sv @@
// ----------------------------------------------------------------------------
// SHA-512 block hash engine
// Hashes a padded message given as 64-bit words and returns the eight digest words.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries one big-endian message word, s_tuser marks the
// first word of a message (the initial hash value is reloaded), s_tlast marks the
// final word, which must be the sixteenth word of its block.
// Output stream: after a block holding the final word, eight transfers carry the
// digest words, index 0 (most significant) first; m_tlast is set on index 7.
// Words pass a four-entry queue into the core. The core loads 16 words of a
// block, one per cycle while the queue holds words, then runs 80 rounds at one
// per cycle and a state-addition step before it reads the next block.
// After a final block it then sends the eight digest words.
// While the core compresses, input transfers fill the queue and then stall.
// When the receiver stalls, the digest holds in the output register and the core
// waits; input stalls once the queue is full.
// Reset clears the queue and block position and loads the initial hash value.
// ----------------------------------------------------------------------------
module sha512_block_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] message_word
	input  logic        s_tuser,   // [0] first_of_message
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] digest_word, [66:64] digest_index, zero fill
	output logic        m_tlast
);
	import sha512_pkg::*;

	entry_t     push_data, pop_data;
	logic       push, q_full, pop, q_valid;
	word_t      dword;
	logic [2:0] didx;

	sha512_front u_front (
		.clk, .arst_n,
		.in_valid (s_tvalid), .in_ready (s_tready), .in_word (s_tdata),
		.in_first (s_tuser), .in_last (s_tlast),
		.push, .push_data, .q_full
	);

	sha512_fifo u_fifo (
		.clk, .arst_n, .push, .push_data, .full (q_full),
		.pop, .not_empty (q_valid), .pop_data
	);

	sha512_core u_core (
		.clk, .arst_n, .q_valid, .q_data (pop_data), .pop,
		.out_valid (m_tvalid), .out_ready (m_tready),
		.out_word (dword), .out_index (didx), .out_last (m_tlast)
	);

	assign m_tdata = {5'd0, didx, dword};

endmodule

@@ bench/tb_sha512_block_hash.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-512 block hash engine testbench
// Streams padded message words into the engine and checks every digest transfer
// against a behavioral compression model kept in step with the accepted words.
// ----------------------------------------------------------------------------
module tb_sha512_block_hash;
	import sha512_pkg::*;

	typedef struct {
		word_t word;
		logic  first;
		logic  last;
	} msg_word_t;

	typedef struct {
		word_t    word;
		bit [2:0] index;
		bit       last;
	} digest_t;

	localparam int IdleLimit = 20000;
	localparam int DrainCycles = 200;

	localparam int PatRandom = 0;
	localparam int PatZero   = 1;
	localparam int PatOnes   = 2;
	localparam int PatAlt    = 3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [63:0] message_word
	logic        s_tuser;   // [0] first_of_message
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // [63:0] digest_word, [66:64] digest_index, zero fill
	logic        m_tlast;

	msg_word_t pending_words[$];
	digest_t   expected_digests[$];
	int        error_count;
	int        idle_cycles;
	int        send_gap;
	int        recv_gap;

	// Model state
	word_t    chain_h[8];
	word_t    block_buf[16];
	bit [3:0] word_pos;
	bit       end_seen;

	sha512_block_hash dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic word_t ror64(word_t v, int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic void compress_into_chain();
		word_t w[80];
		word_t v[8];
		word_t t1, t2;
		for (int t = 0; t < 16; t++) w[t] = block_buf[t];
		for (int t = 16; t < 80; t++) begin
			w[t] = (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
				+ (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
		end
		for (int i = 0; i < 8; i++) v[i] = chain_h[i];
		for (int t = 0; t < 80; t++) begin
			t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
			t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
	endfunction

	function automatic void absorb_word(msg_word_t m);
		digest_t d;
		if (m.first) begin
			for (int i = 0; i < 8; i++) chain_h[i] = START_H[i];
			word_pos = 0;
			end_seen = 0;
		end
		block_buf[word_pos] = m.word;
		if (m.last) end_seen = 1;
		if (word_pos != 4'd15) begin
			word_pos++;
			return;
		end
		word_pos = 0;
		compress_into_chain();
		if (!end_seen) return;
		end_seen = 0;
		for (int k = 0; k < 8; k++) begin
			d.word = chain_h[k];
			d.index = k[2:0];
			d.last = (k == 7);
			expected_digests.insert(expected_digests.size(), d);
		end
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic word_t rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Queue one block; the first word may start a message, the sixteenth or an earlier chosen word may end it.
	function automatic void queue_block(bit first, bit last, int early_last, int pattern);
		msg_word_t m;
		for (int i = 0; i < 16; i++) begin
			case (pattern)
				PatZero: m.word = '0;
				PatOnes: m.word = '1;
				PatAlt:  m.word = (i % 2) ? 64'haaaa_aaaa_aaaa_aaaa : 64'h5555_5555_5555_5555;
				default: m.word = rand_word();
			endcase
			m.first = first && (i == 0);
			m.last = (last && i == 15) || (i == early_last);
			pending_words.insert(pending_words.size(), m);
		end
	endfunction

	// Driver: one transfer per handshake, with random gaps between words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) absorb_word(pending_words.pop_front());
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0 || pending_words.size() == 0) begin
					s_tvalid <= 1'b0;
					if (send_gap > 0) send_gap <= send_gap - 1;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_words[0].word;
					s_tuser <= pending_words[0].first;
					s_tlast <= pending_words[0].last;
					send_gap <= pick_gap();
				end
			end
		end
	end

	// Monitor: checks each digest transfer and throttles the receiver.
	always @(posedge clk or negedge arst_n) begin
		digest_t d;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			idle_cycles <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_digests.size() == 0) begin
					report_mismatch("unexpected digest word", m_tdata[63:0], 0);
				end else begin
					d = expected_digests.pop_front();
					if (m_tdata[63:0] !== d.word) report_mismatch("digest_word", m_tdata[63:0], d.word);
					if (m_tdata[66:64] !== d.index) report_mismatch("digest_index", m_tdata[66:64], d.index);
					if (m_tdata[71:67] !== '0) report_mismatch("zero fill", m_tdata[71:67], 0);
					if (m_tlast !== d.last) report_mismatch("digest_last", m_tlast, d.last);
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IdleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		msg_word_t m;
		arst_n = 1'b0;
		error_count = 0;
		for (int i = 0; i < 8; i++) chain_h[i] = START_H[i];
		word_pos = 0;
		end_seen = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: all-zero and all-one single-block messages, alternating bits.
		queue_block(1, 1, -1, PatZero);
		queue_block(1, 1, -1, PatOnes);
		queue_block(1, 1, -1, PatAlt);
		// Two-block message with the end marker early in the second block.
		queue_block(1, 0, -1, PatRandom);
		queue_block(0, 0, 4, PatRandom);
		// No start marker: chain on from the emitted digest.
		queue_block(0, 1, -1, PatRandom);
		// Partial block dropped by a new start marker.
		for (int i = 0; i < 5; i++) begin
			m.word = rand_word();
			m.first = (i == 0);
			m.last = (i == 2);
			pending_words.insert(pending_words.size(), m);
		end
		queue_block(1, 1, -1, PatRandom);

		wait (pending_words.size() == 0);
		wait (expected_digests.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
